// ===== rtl/rms_envelope_similarity_assert.svh =====
// Assertion macros for the envelope similarity block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef RMS_ENVELOPE_SIMILARITY_ASSERT_SVH
`define RMS_ENVELOPE_SIMILARITY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMSENV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMSENV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rmsenv_pkg.sv =====
// Shared types and constants of the envelope similarity block.
// No dependencies; used by the shift-subtract unit and the top level.
`timescale 1ns / 1ps

package rmsenv_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MAX_WINDOWS = 4096;

  localparam int unsigned ENERGY_W = 38;   // per-window energy
  localparam int unsigned SUM_W    = 44;   // running sums and final root
  localparam int unsigned COUNT_W  = 13;   // window count
  localparam int unsigned ROOT_W   = 19;   // per-window RMS
  localparam int unsigned MUL_W    = 22;   // shared multiplier operand
  localparam int unsigned WIDE_W   = 2 * SUM_W;
  localparam int unsigned REM_W    = SUM_W + 2;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned SIM_W    = 16;
  localparam int unsigned WLEN_W   = 8;

  localparam logic [SIM_W-1:0]   SIM_ONE       = 16'h8000;
  localparam logic [COUNT_W-1:0] MAX_WINDOWS_C = COUNT_W'(MAX_WINDOWS);
  localparam logic [WLEN_W-1:0]  WLEN_RESET    = 8'd44;

  // Iteration counts of the shift-subtract unit
  localparam logic [STEP_W-1:0] DIV_E_STEPS  = 6'd38;
  localparam logic [STEP_W-1:0] SQRT_E_STEPS = 6'd19;
  localparam logic [STEP_W-1:0] SQRT_W_STEPS = 6'd44;
  localparam logic [STEP_W-1:0] DIV_S_STEPS  = 6'd15;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_first;
    logic signed [SAMPLE_BITS-1:0] sample_second;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic [SIM_W-1:0]   similarity;
    logic [COUNT_W-1:0] windows_seen;
    logic               degenerate;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              is_sqrt;
    logic [STEP_W-1:0] steps;
  } shsub_ctrl_t;

endpackage

// ===== rtl/rmsenv_chan_if.sv =====
// Valid/ready stream channel carrying one payload struct.
// Payload type comes in as a parameter; no package dependency.
`timescale 1ns / 1ps

interface rmsenv_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rmsenv_shsub.sv =====
// Shared shift-subtract unit: restoring division and square root, one digit a cycle.
// Depends on rmsenv_pkg for widths and the control struct.
`timescale 1ns / 1ps

module rmsenv_shsub (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmsenv_pkg::shsub_ctrl_t           ctrl_i,
  input  logic [rmsenv_pkg::WIDE_W-1:0]     x_init_i,
  input  logic [rmsenv_pkg::REM_W-1:0]      r_init_i,
  input  logic [rmsenv_pkg::SUM_W-1:0]      d_init_i,
  output logic [rmsenv_pkg::SUM_W-1:0]      q_o,
  output logic                              done_o
);
  import rmsenv_pkg::*;

  logic [REM_W-1:0]  r_q, r_d;
  logic [WIDE_W-1:0] x_q, x_d;
  logic [SUM_W-1:0]  q_q, q_d;
  logic [SUM_W-1:0]  d_q, d_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              sqrt_q, sqrt_d;

  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  subtr;
  logic [REM_W-1:0]  trial;
  logic              take;

  // Square root brings down two bits and tries 4*root+1; division one bit against d.
  always_comb begin
    shifted = sqrt_q ? {r_q[REM_W-3:0], x_q[WIDE_W-1 -: 2]}
                     : {r_q[REM_W-2:0], x_q[WIDE_W-1]};
    subtr   = sqrt_q ? {q_q, 2'b01} : {2'b00, d_q};
    take    = shifted >= subtr;
    trial   = shifted - subtr;
  end

  always_comb begin
    r_d    = r_q;
    x_d    = x_q;
    q_d    = q_q;
    d_d    = d_q;
    cnt_d  = cnt_q;
    sqrt_d = sqrt_q;
    if (ctrl_i.load) begin
      r_d    = r_init_i;
      x_d    = x_init_i;
      q_d    = '0;
      d_d    = d_init_i;
      cnt_d  = ctrl_i.steps;
      sqrt_d = ctrl_i.is_sqrt;
    end else if (cnt_q != '0) begin
      r_d   = take ? trial : shifted;
      x_d   = sqrt_q ? {x_q[WIDE_W-3:0], 2'b00} : {x_q[WIDE_W-2:0], 1'b0};
      q_d   = {q_q[SUM_W-2:0], take};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sqrt_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sqrt_q <= sqrt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    q_q <= q_d;
    d_q <= d_d;
  end

  assign q_o    = q_q;
  assign done_o = (cnt_q == '0);

endmodule

// ===== rtl/rms_envelope_similarity.sv =====
// Envelope similarity of two sample streams: top level and sequencer.
// Depends on rmsenv_pkg, rmsenv_chan_if, rmsenv_shsub and the assertion header.
//
// Usage:
//   in_i carries paired signed samples and a last flag; out_o carries one result
//   per stream, given on the request that has last_sample set. cfg_we_i/cfg_wdata_i
//   write the window length; write it only while the block is idle.
//   A request that does not close a window steps through S_SQA, S_SQB and S_ACCB.
//   Closing a window adds, per signal, a 38-step division of the window energy by
//   the length and a 19-step square root, both on the one shared shift-subtract
//   unit, then three products on the shared 22x22 multiplier. The last request
//   adds four partial products for the 88-bit energy product, a 44-step square
//   root and a 15-step division, again on the shared unit. in_i.ready is high
//   only while the sequencer is idle.
//   The result sits in an output register; a new stream may start while it waits,
//   and the sequencer holds at its final step until the receiver frees that register.
//   Reset clears all stream state, sets the window length to 44 and drops any
//   pending result.
`timescale 1ns / 1ps
`include "rms_envelope_similarity_assert.svh"

module rms_envelope_similarity (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmsenv_pkg::WLEN_W-1:0]   cfg_wdata_i,
  rmsenv_chan_if.sink                     in_i,
  rmsenv_chan_if.source                   out_o
);
  import rmsenv_pkg::*;

  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_SQA      = 5'd1;
  localparam logic [ST_W-1:0] S_SQB      = 5'd2;
  localparam logic [ST_W-1:0] S_ACCB     = 5'd3;
  localparam logic [ST_W-1:0] S_DIVA_LD  = 5'd4;
  localparam logic [ST_W-1:0] S_DIVA_RUN = 5'd5;
  localparam logic [ST_W-1:0] S_SQRA_LD  = 5'd6;
  localparam logic [ST_W-1:0] S_SQRA_RUN = 5'd7;
  localparam logic [ST_W-1:0] S_DIVB_LD  = 5'd8;
  localparam logic [ST_W-1:0] S_DIVB_RUN = 5'd9;
  localparam logic [ST_W-1:0] S_SQRB_LD  = 5'd10;
  localparam logic [ST_W-1:0] S_SQRB_RUN = 5'd11;
  localparam logic [ST_W-1:0] S_PAB      = 5'd12;
  localparam logic [ST_W-1:0] S_PAA      = 5'd13;
  localparam logic [ST_W-1:0] S_PBB      = 5'd14;
  localparam logic [ST_W-1:0] S_WEND     = 5'd15;
  localparam logic [ST_W-1:0] S_FIN      = 5'd16;
  localparam logic [ST_W-1:0] S_M1       = 5'd17;
  localparam logic [ST_W-1:0] S_M2       = 5'd18;
  localparam logic [ST_W-1:0] S_M3       = 5'd19;
  localparam logic [ST_W-1:0] S_M4       = 5'd20;
  localparam logic [ST_W-1:0] S_SQD_LD   = 5'd21;
  localparam logic [ST_W-1:0] S_SQD_RUN  = 5'd22;
  localparam logic [ST_W-1:0] S_DIVS     = 5'd23;
  localparam logic [ST_W-1:0] S_DIVS_RUN = 5'd24;
  localparam logic [ST_W-1:0] S_EMIT     = 5'd25;

  localparam int unsigned PROD_W = 2 * MUL_W;

  function automatic logic [SAMPLE_BITS-1:0] mag_of(logic [SAMPLE_BITS-1:0] v);
    mag_of = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  logic [ST_W-1:0]        state_q, state_d;
  logic [WLEN_W-1:0]      wlen_q, wlen_d;
  logic [SAMPLE_BITS-1:0] mag_a_q, mag_a_d;
  logic [SAMPLE_BITS-1:0] mag_b_q, mag_b_d;
  logic                   last_q, last_d;
  logic [ENERGY_W-1:0]    ea_q, ea_d;
  logic [ENERGY_W-1:0]    eb_q, eb_d;
  logic [WLEN_W-1:0]      siw_q, siw_d;
  logic [COUNT_W-1:0]     wc_q, wc_d;
  logic [SUM_W-1:0]       cross_q, cross_d;
  logic [SUM_W-1:0]       esa_q, esa_d;
  logic [SUM_W-1:0]       esb_q, esb_d;
  logic                   ovf_q, ovf_d;
  logic [ROOT_W-1:0]      ra_q, ra_d;
  logic [ROOT_W-1:0]      rb_q, rb_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [WIDE_W-1:0]      acc_q, acc_d;
  logic [SIM_W-1:0]       sim_q, sim_d;
  logic                   degen_q, degen_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_data_q, out_data_d;

  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [ENERGY_W:0]      e_sum;
  logic [SUM_W:0]         s_sum;
  logic [WLEN_W-1:0]      len;
  logic [WLEN_W-1:0]      siw_next;
  logic                   win_done;

  shsub_ctrl_t            unit_ctrl;
  logic [WIDE_W-1:0]      unit_x;
  logic [REM_W-1:0]       unit_r;
  logic [SUM_W-1:0]       unit_d;
  logic [SUM_W-1:0]       unit_q;
  logic                   unit_done;

  rmsenv_shsub u_shsub (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (unit_ctrl),
    .x_init_i (unit_x),
    .r_init_i (unit_r),
    .d_init_i (unit_d),
    .q_o      (unit_q),
    .done_o   (unit_done)
  );

  assign len      = (wlen_q == '0) ? WLEN_W'(1) : wlen_q;
  assign siw_next = siw_q + 1'b1;
  // A wrapped count also closes the window
  assign win_done = (siw_next >= len) || (siw_next == '0);

  // Shared multiplier operands; product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQA: begin
        mul_a = MUL_W'(mag_a_q);
        mul_b = MUL_W'(mag_a_q);
      end
      S_SQB: begin
        mul_a = MUL_W'(mag_b_q);
        mul_b = MUL_W'(mag_b_q);
      end
      S_PAB: begin
        mul_a = MUL_W'(ra_q);
        mul_b = MUL_W'(rb_q);
      end
      S_PAA: begin
        mul_a = MUL_W'(ra_q);
        mul_b = MUL_W'(ra_q);
      end
      S_PBB: begin
        mul_a = MUL_W'(rb_q);
        mul_b = MUL_W'(rb_q);
      end
      S_FIN: begin
        mul_a = esa_q[MUL_W-1:0];
        mul_b = esb_q[MUL_W-1:0];
      end
      S_M1: begin
        mul_a = esa_q[MUL_W-1:0];
        mul_b = esb_q[SUM_W-1:MUL_W];
      end
      S_M2: begin
        mul_a = esa_q[SUM_W-1:MUL_W];
        mul_b = esb_q[MUL_W-1:0];
      end
      S_M3: begin
        mul_a = esa_q[SUM_W-1:MUL_W];
        mul_b = esb_q[SUM_W-1:MUL_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_d     = state_q;
    wlen_d      = cfg_we_i ? cfg_wdata_i : wlen_q;
    mag_a_d     = mag_a_q;
    mag_b_d     = mag_b_q;
    last_d      = last_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    siw_d       = siw_q;
    wc_d        = wc_q;
    cross_d     = cross_q;
    esa_d       = esa_q;
    esb_d       = esb_q;
    ovf_d       = ovf_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    acc_d       = acc_q;
    sim_d       = sim_q;
    degen_d     = degen_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    e_sum       = '0;
    s_sum       = '0;
    unit_ctrl   = '0;
    unit_x      = '0;
    unit_r      = '0;
    unit_d      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mag_a_d = mag_of(in_i.data.sample_first);
          mag_b_d = mag_of(in_i.data.sample_second);
          last_d  = in_i.data.last_sample;
          state_d = S_SQA;
        end
      end
      S_SQA: state_d = S_SQB;
      S_SQB: begin
        e_sum   = {1'b0, ea_q} + {1'b0, prod_q[ENERGY_W-1:0]};
        ea_d    = e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
        ovf_d   = ovf_q | e_sum[ENERGY_W];
        state_d = S_ACCB;
      end
      S_ACCB: begin
        e_sum = {1'b0, eb_q} + {1'b0, prod_q[ENERGY_W-1:0]};
        eb_d  = e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
        ovf_d = ovf_q | e_sum[ENERGY_W];
        if (win_done) begin
          siw_d   = '0;
          state_d = S_DIVA_LD;
        end else begin
          siw_d   = siw_next;
          state_d = last_q ? S_FIN : S_IDLE;
        end
      end
      S_DIVA_LD: begin
        unit_ctrl = '{load: 1'b1, is_sqrt: 1'b0, steps: DIV_E_STEPS};
        unit_x    = {ea_q, {(WIDE_W-ENERGY_W){1'b0}}};
        unit_d    = SUM_W'(len);
        state_d   = S_DIVA_RUN;
      end
      S_DIVA_RUN: if (unit_done) state_d = S_SQRA_LD;
      S_SQRA_LD: begin
        unit_ctrl = '{load: 1'b1, is_sqrt: 1'b1, steps: SQRT_E_STEPS};
        unit_x    = {unit_q[ENERGY_W-1:0], {(WIDE_W-ENERGY_W){1'b0}}};
        state_d   = S_SQRA_RUN;
      end
      S_SQRA_RUN: begin
        if (unit_done) begin
          ra_d    = unit_q[ROOT_W-1:0];
          state_d = S_DIVB_LD;
        end
      end
      S_DIVB_LD: begin
        unit_ctrl = '{load: 1'b1, is_sqrt: 1'b0, steps: DIV_E_STEPS};
        unit_x    = {eb_q, {(WIDE_W-ENERGY_W){1'b0}}};
        unit_d    = SUM_W'(len);
        state_d   = S_DIVB_RUN;
      end
      S_DIVB_RUN: if (unit_done) state_d = S_SQRB_LD;
      S_SQRB_LD: begin
        unit_ctrl = '{load: 1'b1, is_sqrt: 1'b1, steps: SQRT_E_STEPS};
        unit_x    = {unit_q[ENERGY_W-1:0], {(WIDE_W-ENERGY_W){1'b0}}};
        state_d   = S_SQRB_RUN;
      end
      S_SQRB_RUN: begin
        if (unit_done) begin
          rb_d    = unit_q[ROOT_W-1:0];
          state_d = S_PAB;
        end
      end
      S_PAB: state_d = S_PAA;
      S_PAA: begin
        s_sum   = {1'b0, cross_q} + {1'b0, prod_q};
        cross_d = s_sum[SUM_W] ? '1 : s_sum[SUM_W-1:0];
        ovf_d   = ovf_q | s_sum[SUM_W];
        state_d = S_PBB;
      end
      S_PBB: begin
        s_sum   = {1'b0, esa_q} + {1'b0, prod_q};
        esa_d   = s_sum[SUM_W] ? '1 : s_sum[SUM_W-1:0];
        ovf_d   = ovf_q | s_sum[SUM_W];
        state_d = S_WEND;
      end
      S_WEND: begin
        s_sum = {1'b0, esb_q} + {1'b0, prod_q};
        esb_d = s_sum[SUM_W] ? '1 : s_sum[SUM_W-1:0];
        // Count holds at its ceiling and flags saturation
        if (wc_q >= MAX_WINDOWS_C) begin
          wc_d  = MAX_WINDOWS_C;
          ovf_d = 1'b1;
        end else begin
          wc_d  = wc_q + 1'b1;
          ovf_d = ovf_q | s_sum[SUM_W];
        end
        ea_d    = '0;
        eb_d    = '0;
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (wc_q < COUNT_W'(2)) begin
          sim_d   = '0;
          degen_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_M1;
        end
      end
      S_M1: begin
        acc_d   = {{(WIDE_W-PROD_W){1'b0}}, prod_q};
        state_d = S_M2;
      end
      S_M2: begin
        acc_d   = acc_q + {{MUL_W{1'b0}}, prod_q, {MUL_W{1'b0}}};
        state_d = S_M3;
      end
      S_M3: begin
        acc_d   = acc_q + {{MUL_W{1'b0}}, prod_q, {MUL_W{1'b0}}};
        state_d = S_M4;
      end
      S_M4: begin
        acc_d   = acc_q + {prod_q, {(WIDE_W-PROD_W){1'b0}}};
        state_d = S_SQD_LD;
      end
      S_SQD_LD: begin
        unit_ctrl = '{load: 1'b1, is_sqrt: 1'b1, steps: SQRT_W_STEPS};
        unit_x    = acc_q;
        state_d   = S_SQD_RUN;
      end
      S_SQD_RUN: if (unit_done) state_d = S_DIVS;
      S_DIVS: begin
        if (unit_q == '0) begin
          sim_d   = '0;
          degen_d = 1'b1;
          state_d = S_EMIT;
        end else if (cross_q >= unit_q) begin
          // Quotient at or above one: clamp
          sim_d   = SIM_ONE;
          degen_d = 1'b0;
          state_d = S_EMIT;
        end else begin
          // Remainder starts at the cross sum; shift in zeros for the fraction
          unit_ctrl = '{load: 1'b1, is_sqrt: 1'b0, steps: DIV_S_STEPS};
          unit_r    = {2'b00, cross_q};
          unit_d    = unit_q;
          state_d   = S_DIVS_RUN;
        end
      end
      S_DIVS_RUN: begin
        if (unit_done) begin
          sim_d   = {1'b0, unit_q[SIM_W-2:0]};
          degen_d = 1'b0;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_data_d.similarity   = sim_q;
          out_data_d.windows_seen = wc_q;
          out_data_d.degenerate   = degen_q;
          out_data_d.saturated    = ovf_q;
          out_valid_d = 1'b1;
          ea_d        = '0;
          eb_d        = '0;
          siw_d       = '0;
          wc_d        = '0;
          cross_d     = '0;
          esa_d       = '0;
          esb_d       = '0;
          ovf_d       = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wlen_q      <= WLEN_RESET;
      ea_q        <= '0;
      eb_q        <= '0;
      siw_q       <= '0;
      wc_q        <= '0;
      cross_q     <= '0;
      esa_q       <= '0;
      esb_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wlen_q      <= wlen_d;
      ea_q        <= ea_d;
      eb_q        <= eb_d;
      siw_q       <= siw_d;
      wc_q        <= wc_d;
      cross_q     <= cross_d;
      esa_q       <= esa_d;
      esb_q       <= esb_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q    <= mag_a_d;
    mag_b_q    <= mag_b_d;
    last_q     <= last_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    sim_q      <= sim_d;
    degen_q    <= degen_d;
    out_data_q <= out_data_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  `RMSENV_ASSERT_IMP(a_rose_from_emit, $rose(out_valid_q), $past(state_q) == S_EMIT, "result raised outside the emit step")
  `RMSENV_ASSERT_NXT(a_emit_clears, (state_q == S_EMIT) && (!out_valid_q || out_o.ready), out_valid_q && (wc_q == '0) && !ovf_q && (state_q == S_IDLE), "stream state not cleared on emit")
  `RMSENV_ASSERT_IMP(a_degen_zero, out_valid_q && out_data_q.degenerate, out_data_q.similarity == '0, "degenerate result with nonzero similarity")
  `RMSENV_ASSERT_IMP(a_count_cap, 1'b1, wc_q <= MAX_WINDOWS_C, "window count above ceiling")

endmodule

// ===== tb/tb_rms_envelope_similarity.sv =====
// Self-checking bench for the envelope similarity block: a table of directed
// requests, a long stream that saturates the window count, then random streams.
// Depends on rmsenv_pkg, rmsenv_chan_if and the rms_envelope_similarity top level.
`timescale 1ns / 1ps

module tb_rms_envelope_similarity;
  import rmsenv_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 8_000_000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned IDLE_PAUSE   = 300;
  localparam int          RANDOM_ITEMS = 1550;
  localparam logic [63:0] ENERGY_CAP   = (64'd1 << ENERGY_W) - 64'd1;
  localparam logic [63:0] SUM_CAP      = (64'd1 << SUM_W) - 64'd1;

  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_QUIET, MIX_ONE_SILENT, MIX_TRACKING}
    sample_mix_e;

  typedef struct packed {
    logic                   wr;
    logic [WLEN_W-1:0]      wlen;
    logic signed [15:0]     a;
    logic signed [15:0]     b;
    logic                   last;
    logic                   typed;
    out_item_t              want;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [WLEN_W-1:0]  cfg_wdata;
  bit                 steady;
  bit                 hold_req;
  int                 err_cnt;
  int unsigned        cycle_cnt;

  // Shadow of the block: per-window energies, running sums, flags
  logic [WLEN_W-1:0]  m_wlen;
  logic [37:0]        m_wen_a, m_wen_b;
  logic [7:0]         m_fill;
  logic [COUNT_W-1:0] m_wins;
  logic [43:0]        m_xsum, m_esum_a, m_esum_b;
  bit                 m_sat;

  out_item_t          similarity_due[$];

  rmsenv_chan_if #(.payload_t(in_item_t))  req_if ();
  rmsenv_chan_if #(.payload_t(out_item_t)) res_if ();

  rms_envelope_similarity DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  dir_row_t dir_rows [23] = '{
    '{1'b0, 8'd0,  16'sh7FFF,    16'sh8000,    1'b1, 1'b1, '{16'd0, 13'd0, 1'b1, 1'b0}},
    '{1'b1, 8'd1,  16'sh7FFF,    16'sh7FFF,    1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sh8000,    16'sh8000,    1'b1, 1'b1, '{SIM_ONE, 13'd2, 1'b0, 1'b0}},
    '{1'b1, 8'd0,  16'sd100,     16'sd0,       1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd0,       16'sd100,     1'b1, 1'b1, '{16'd0, 13'd2, 1'b0, 1'b0}},
    '{1'b0, 8'd0,  16'sd0,       16'sd0,       1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd0,       16'sd0,       1'b1, 1'b1, '{16'd0, 13'd2, 1'b1, 1'b0}},
    '{1'b0, 8'd0,  16'sd1234,    16'sd0,       1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  -16'sd77,     16'sd0,       1'b1, 1'b1, '{16'd0, 13'd2, 1'b1, 1'b0}},
    '{1'b1, 8'd2,  16'sd5,       16'sd5,       1'b1, 1'b1, '{16'd0, 13'd0, 1'b1, 1'b0}},
    '{1'b0, 8'd0,  16'sh8000,    16'sh7FFF,    1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd1,       -16'sd1,      1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  -16'sd1,      16'sd1,       1'b1, 1'b1, '{16'd0, 13'd1, 1'b1, 1'b0}},
    '{1'b1, 8'd8,  16'sd300,     -16'sd300,    1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  -16'sd20000,  16'sd12000,   1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd7,       16'sd9,       1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd16384,   -16'sd16384,  1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd1,       16'sd2,       1'b0, 1'b0, '0},
    // shorten the window while five samples sit in it
    '{1'b1, 8'd3,  -16'sd5000,   16'sd4000,    1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sd123,     16'sd456,     1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  -16'sd999,    16'sd888,     1'b0, 1'b0, '0},
    '{1'b0, 8'd0,  16'sh7FFF,    -16'sd1,      1'b1, 1'b0, '0},
    '{1'b1, 8'd44, 16'sd2500,    -16'sd2500,   1'b1, 1'b1, '{16'd0, 13'd0, 1'b1, 1'b0}}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= v) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] sample_power(input logic signed [15:0] s);
    logic [16:0] mag;
    mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    return 64'(mag) * 64'(mag);
  endfunction

  function automatic logic [63:0] clamp_add(input logic [63:0] acc, input logic [63:0] add,
                                            input logic [63:0] lim);
    if (acc > lim || add > lim - acc) begin
      m_sat = 1'b1;
      return lim;
    end
    return acc + add;
  endfunction

  task automatic clear_stream_state();
    m_wen_a  = '0;
    m_wen_b  = '0;
    m_fill   = '0;
    m_wins   = '0;
    m_xsum   = '0;
    m_esum_a = '0;
    m_esum_b = '0;
    m_sat    = 1'b0;
  endtask

  // Advance the shadow by one request; queue the result when the stream closes
  task automatic predict_similarity(input in_item_t it, input bit typed, input out_item_t want);
    logic [63:0]  eff;
    logic [63:0]  ra, rb, d, sim;
    logic [127:0] prod;
    out_item_t    res;
    eff = (m_wlen == '0) ? 64'd1 : 64'(m_wlen);
    m_wen_a = 38'(clamp_add(64'(m_wen_a), sample_power(it.sample_first), ENERGY_CAP));
    m_wen_b = 38'(clamp_add(64'(m_wen_b), sample_power(it.sample_second), ENERGY_CAP));
    m_fill  = m_fill + 8'd1;
    if (64'(m_fill) >= eff || m_fill == 8'd0) begin
      ra = int_sqrt(128'(64'(m_wen_a) / eff));
      rb = int_sqrt(128'(64'(m_wen_b) / eff));
      m_xsum   = 44'(clamp_add(64'(m_xsum), ra * rb, SUM_CAP));
      m_esum_a = 44'(clamp_add(64'(m_esum_a), ra * ra, SUM_CAP));
      m_esum_b = 44'(clamp_add(64'(m_esum_b), rb * rb, SUM_CAP));
      if (m_wins >= MAX_WINDOWS_C) begin
        m_wins = MAX_WINDOWS_C;
        m_sat  = 1'b1;
      end else begin
        m_wins = m_wins + 1'b1;
      end
      m_wen_a = '0;
      m_wen_b = '0;
      m_fill  = '0;
    end
    if (it.last_sample) begin
      sim = '0;
      res.degenerate = 1'b1;
      if (m_wins >= 2) begin
        prod = 128'(m_esum_a) * 128'(m_esum_b);
        d = int_sqrt(prod);
        if (d != '0) begin
          res.degenerate = 1'b0;
          sim = (64'(m_xsum) << 15) / d;
          if (sim > 64'd32768) sim = 64'd32768;
        end
      end
      res.similarity   = 16'(sim);
      res.windows_seen = m_wins;
      res.saturated    = m_sat;
      similarity_due.push_back(typed ? want : res);
      clear_stream_state();
    end
  endtask

  // Offer one request from a falling edge; return at the edge that takes it
  task automatic send_item(input logic signed [15:0] a, input logic signed [15:0] b,
                           input bit last, input bit typed, input out_item_t want);
    in_item_t it;
    it = '{sample_first: a, sample_second: b, last_sample: last};
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predict_similarity(it, typed, want);
  endtask

  // Write only once the block has drained and settled
  task automatic write_window_length(input logic [WLEN_W-1:0] v);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (similarity_due.size() != 0) @(negedge clk_i);
    repeat (IDLE_PAUSE) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    m_wlen = v;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  initial begin : res_drain
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold off long enough for the block to fill and stall requests
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(posedge clk_i) begin : res_mon
    out_item_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (similarity_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res_if.data);
        err_cnt++;
      end else begin
        want = similarity_due.pop_front();
        check_field("similarity", want.similarity, res_if.data.similarity);
        check_field("windows_seen", 16'(want.windows_seen), 16'(res_if.data.windows_seen));
        check_field("degenerate", 16'(want.degenerate), 16'(res_if.data.degenerate));
        check_field("saturated", 16'(want.saturated), 16'(res_if.data.saturated));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stim
    int          n, nwin, nstreams, eff, phase, rand_items;
    logic [7:0]  wl;
    logic signed [15:0] a, b;
    sample_mix_e mix;
    cycle_cnt    = 0;
    err_cnt      = 0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    m_wlen       = WLEN_RESET;
    clear_stream_state();
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) write_window_length(dir_rows[i].wlen);
      send_item(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                dir_rows[i].want);
    end

    // Short streams against a stalled receiver
    write_window_length(8'd1);
    hold_req = 1'b1;
    repeat (8) begin
      send_item(16'($urandom), 16'($urandom), 1'b0, 1'b0, '0);
      send_item(16'($urandom), 16'($urandom), 1'b1, 1'b0, '0);
    end

    // One window per request, past the window count ceiling
    for (int k = 0; k < int'(MAX_WINDOWS) + 4; k++)
      send_item(16'($urandom), 16'($urandom), k == int'(MAX_WINDOWS) + 3, 1'b0, '0);

    phase = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case (phase)
        0: wl = 8'd1;
        1: wl = 8'd255;
        2: wl = 8'd0;
        default: wl = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1))
                                               : 8'($urandom_range(12, 1));
      endcase
      write_window_length(wl);
      steady = (phase == 3);
      eff = (wl == 8'd0) ? 1 : int'(wl);
      nstreams = (eff >= 100) ? int'($urandom_range(2, 1)) : int'($urandom_range(6, 2));
      repeat (nstreams) begin
        nwin = (eff >= 100) ? int'($urandom_range(2)) : int'($urandom_range(10));
        n = nwin * eff + int'($urandom_range(eff - 1));
        if (n == 0) n = 1;
        mix = sample_mix_e'($urandom_range(4));
        for (int k = 0; k < n; k++) begin
          a = 16'($urandom);
          b = 16'($urandom);
          case (mix)
            MIX_EXTREME: begin
              a = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
              b = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            MIX_QUIET: begin
              a = 16'($urandom_range(127) - 64);
              b = 16'($urandom_range(127) - 64);
            end
            MIX_ONE_SILENT: begin
              if ($urandom_range(1)) a = '0;
              else b = '0;
            end
            MIX_TRACKING: begin
              case ($urandom_range(2))
                0: b = a;
                1: b = -a;
                default: b = a >>> 1;
              endcase
            end
            default: ;
          endcase
          send_item(a, b, k == n - 1, 1'b0, '0);
        end
        rand_items += n;
      end
      phase++;
    end
    steady = 1'b0;

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (similarity_due.size() != 0) @(negedge clk_i);
    repeat (IDLE_PAUSE) @(negedge clk_i);
    if (err_cnt == 0 && similarity_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== rms_envelope_similarity.f =====
+incdir+rtl
rtl/rmsenv_pkg.sv
rtl/rmsenv_chan_if.sv
rtl/rmsenv_shsub.sv
rtl/rms_envelope_similarity.sv
tb/tb_rms_envelope_similarity.sv
